### design/wss_pkg.sv
package wss_pkg;

   localparam int LEVEL_BITS = 11;

   // trigger level bit positions
   localparam int TRIG_RUN     = 0;
   localparam int TRIG_COPY    = 1;
   localparam int TRIG_PASTE   = 2;
   localparam int TRIG_CHANNEL = 3;
   localparam int TRIG_GATE    = 4;
   localparam int TRIG_LEFT    = 5;
   localparam int TRIG_RIGHT   = 6;
   localparam int TRIG_WRITE   = 7;
   localparam int TRIG_RESET   = 8;
   localparam int TRIG_CLK_A   = 9;
   localparam int TRIG_CLK_B   = 10;

   localparam logic [1:0] CSR_QUANTIZE   = 2'd0;
   localparam logic [1:0] CSR_AUTOSTEP   = 2'd1;
   localparam logic [1:0] CSR_PASTE_SYNC = 2'd2;
   localparam logic [1:0] CSR_MONITOR    = 2'd3;

   localparam logic [1:0] SYNC_NOW   = 2'd0;
   localparam logic [1:0] PEND_NONE  = 2'd0;
   localparam logic [1:0] PEND_CLOCK = 2'd1;
   localparam logic [1:0] PEND_START = 2'd2;

   typedef struct packed {
      logic [10:0]        trigger_levels;
      logic               clock_b_connected;
      logic signed [15:0] length_knob_position;
      logic signed [15:0] step_knob_position;
      logic signed [15:0] cv_in;
      logic               gate_in_connected;
      logic               gate_in_high;
   } req_type;

   typedef struct packed {
      logic signed [15:0] cv_out_0;
      logic signed [15:0] cv_out_1;
      logic signed [15:0] cv_out_2;
      logic signed [15:0] cv_out_3;
      logic [3:0]         gate_outs;
      logic [2:0]         selected_track;
      logic [5:0]         current_step;
      logic [6:0]         track_length;
      logic [3:0]         status_lights;
   } rsp_type;

   typedef struct packed {
      logic       quantize_enable;
      logic       autostep_enable;
      logic [1:0] paste_sync_mode;
      logic       monitor_mode;
   } cfg_type;

   // classified request handed from front to back
   typedef struct packed {
      logic [10:0]        rise;
      logic [10:0]        levels;
      logic               b_conn;
      logic signed [2:0]  len_delta;
      logic signed [2:0]  step_delta;
      logic signed [15:0] cv_in;
      logic               gate_conn;
      logic               gate_high;
   } work_type;

   function automatic logic signed [15:0] quantize(logic signed [15:0] v, logic en);
      logic signed [17:0] w;
      logic signed [17:0] t;
      logic signed [17:0] q;
      w = {{2{v[15]}}, v};
      if (!w[17]) begin
         t = w + 18'sd128;
         q = {t[17:8], 8'b0};
      end else begin
         t = -w + 18'sd128;
         q = -$signed({t[17:8], 8'b0});
      end
      if (q > 18'sd32767) q = 18'sd32512;
      if (!en) q = w;
      return q[15:0];
   endfunction

endpackage

### design/writable_step_sequencer.sv
// channel  | handshake               | payload
// req      | req_valid / req_stall   | req_data  (wss_pkg::req_type)
// rsp      | rsp_valid / rsp_stall   | rsp_data  (wss_pkg::rsp_type)
// csr      | csr_we                  | csr_index, csr_wdata
//
// In the back end a request runs from pop through decode, edit, knobs, clock, move,
// output reads and result; a gate toggle or a write adds a step read and write;
// a copy or a paste moves one memory entry per cycle between store and clip memory.
// After reset a pass clears all STEPS_PER_TRACK*TRACK_COUNT entries (320 by default)
// before the back end pops the first request; csr writes are taken throughout.
// A two-entry queue takes requests while the back end works or a response is stalled.
module writable_step_sequencer #(
   parameter int STEPS_PER_TRACK = 64,
   parameter int TRACK_COUNT     = 5
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  wss_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output wss_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [1:0]       csr_wdata
);

   wss_pkg::cfg_type  cfg_ff, cfg_in;
   wss_pkg::work_type push_data, pop_data;
   logic              push, full, pop_valid, pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            wss_pkg::CSR_QUANTIZE:   cfg_in.quantize_enable = csr_wdata[0];
            wss_pkg::CSR_AUTOSTEP:   cfg_in.autostep_enable = csr_wdata[0];
            wss_pkg::CSR_PASTE_SYNC: cfg_in.paste_sync_mode = csr_wdata;
            wss_pkg::CSR_MONITOR:    cfg_in.monitor_mode    = csr_wdata[0];
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{quantize_enable: 1'b1, autostep_enable: 1'b1,
                     paste_sync_mode: wss_pkg::SYNC_NOW, monitor_mode: 1'b0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   wss_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .q_full(full), .q_push(push), .q_data(push_data)
   );

   wss_queue u_queue (
      .clock(clock), .reset(reset),
      .push(push), .push_data(push_data), .full(full),
      .pop_valid(pop_valid), .pop(pop), .pop_data(pop_data)
   );

   wss_back #(.STEPS_PER_TRACK(STEPS_PER_TRACK), .TRACK_COUNT(TRACK_COUNT)) u_back (
      .clock(clock), .reset(reset),
      .q_valid(pop_valid), .q_data(pop_data), .q_pop(pop),
      .cfg(cfg_ff),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

endmodule

### design/wss_ram.sv
module wss_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 320
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/wss_front.sv
module wss_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  wss_pkg::req_type  req_data,
   input  logic              q_full,
   output logic              q_push,
   output wss_pkg::work_type q_data
);

   logic [10:0]        prev_lv_ff, prev_lv_in;
   logic signed [15:0] last_len_ff, last_len_in;
   logic signed [15:0] last_step_ff, last_step_in;
   logic signed [16:0] len_d, step_d;
   logic               accept;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign q_push    = accept;

   always_comb begin
      len_d  = {req_data.length_knob_position[15], req_data.length_knob_position}
             - {last_len_ff[15], last_len_ff};
      step_d = {req_data.step_knob_position[15], req_data.step_knob_position}
             - {last_step_ff[15], last_step_ff};

      q_data.rise      = req_data.trigger_levels & ~prev_lv_ff;
      q_data.levels    = req_data.trigger_levels;
      q_data.b_conn    = req_data.clock_b_connected;
      q_data.cv_in     = req_data.cv_in;
      q_data.gate_conn = req_data.gate_in_connected;
      q_data.gate_high = req_data.gate_in_high;
      // jumps larger than two detents are dropped
      q_data.len_delta = (len_d >= -17'sd2 && len_d <= 17'sd2) ? len_d[2:0] : 3'sd0;
      q_data.step_delta = (step_d >= -17'sd2 && step_d <= 17'sd2) ? step_d[2:0] : 3'sd0;

      prev_lv_in   = prev_lv_ff;
      last_len_in  = last_len_ff;
      last_step_in = last_step_ff;
      if (accept) begin
         prev_lv_in   = req_data.trigger_levels;
         last_len_in  = req_data.length_knob_position;
         last_step_in = req_data.step_knob_position;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_lv_ff   <= '0;
         last_len_ff  <= '0;
         last_step_ff <= '0;
      end else begin
         prev_lv_ff   <= prev_lv_in;
         last_len_ff  <= last_len_in;
         last_step_ff <= last_step_in;
      end
   end

endmodule

### design/wss_queue.sv
module wss_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  wss_pkg::work_type push_data,
   output logic              full,
   output logic              pop_valid,
   input  logic              pop,
   output wss_pkg::work_type pop_data
);

   wss_pkg::work_type ent_ff [2];
   wss_pkg::work_type ent_in [2];
   logic       wp_ff, wp_in;
   logic       rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full      = (cnt_ff == 2'd2);
   assign pop_valid = (cnt_ff != 2'd0);
   assign pop_data  = ent_ff[rp_ff];

   always_comb begin
      ent_in = ent_ff;
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      cnt_in = cnt_ff;
      if (push) begin
         ent_in[wp_ff] = push_data;
         wp_in = ~wp_ff;
      end
      if (pop) rp_in = ~rp_ff;
      if (push && !pop) cnt_in = cnt_ff + 2'd1;
      if (pop && !push) cnt_in = cnt_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

### design/wss_back.sv
module wss_back #(
   parameter int STEPS_PER_TRACK = 64,
   parameter int TRACK_COUNT     = 5
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  wss_pkg::work_type q_data,
   output logic              q_pop,
   input  wss_pkg::cfg_type  cfg,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output wss_pkg::rsp_type  rsp_data
);

   localparam int STORE_DEPTH = STEPS_PER_TRACK * TRACK_COUNT;
   localparam int AW     = $clog2(STORE_DEPTH);
   localparam int SW     = $clog2(STEPS_PER_TRACK);
   localparam int LW     = $clog2(STEPS_PER_TRACK + 1);
   localparam int TW     = $clog2(TRACK_COUNT);
   localparam int CW     = $clog2(STORE_DEPTH + 1);
   localparam int PLAYED = (TRACK_COUNT - 1) > 4 ? 4 : (TRACK_COUNT - 1);
   localparam logic [TW-1:0] STAGE = TW'(TRACK_COUNT - 1);
   localparam int DW = 17;

   localparam logic [4:0] ST_CLEAR = 5'd0;
   localparam logic [4:0] ST_IDLE  = 5'd1;
   localparam logic [4:0] ST_FRONT = 5'd2;
   localparam logic [4:0] ST_COPY  = 5'd3;
   localparam logic [4:0] ST_PDEC  = 5'd4;
   localparam logic [4:0] ST_PASTE = 5'd5;
   localparam logic [4:0] ST_EDIT  = 5'd6;
   localparam logic [4:0] ST_GREAD = 5'd7;
   localparam logic [4:0] ST_GWR   = 5'd8;
   localparam logic [4:0] ST_KNOB  = 5'd9;
   localparam logic [4:0] ST_CLK   = 5'd10;
   localparam logic [4:0] ST_MOVE  = 5'd11;
   localparam logic [4:0] ST_WREAD = 5'd12;
   localparam logic [4:0] ST_WWR   = 5'd13;
   localparam logic [4:0] ST_ORD   = 5'd14;
   localparam logic [4:0] ST_OCAP  = 5'd15;
   localparam logic [4:0] ST_SREAD = 5'd16;
   localparam logic [4:0] ST_SCAP  = 5'd17;
   localparam logic [4:0] ST_DONE  = 5'd18;

   function automatic logic [SW-1:0] move_to(logic [SW-1:0] cur, logic signed [2:0] d,
                                             logic [LW-1:0] n);
      logic signed [LW+1:0] cc;
      logic signed [LW+1:0] nn;
      logic signed [LW+1:0] nx;
      logic [SW-1:0]        r;
      cc = $signed((LW+2)'(cur));
      nn = $signed((LW+2)'(n));
      nx = cc + (LW+2)'(d);
      if (nx < 0) r = SW'(n - 1'b1);
      else if (nx >= nn) r = (nx >= cc) ? '0 : SW'(n - 1'b1);
      else r = SW'(nx);
      return r;
   endfunction

   function automatic logic [LW-1:0] sat_len(logic [LW-1:0] n, logic signed [2:0] d);
      logic signed [LW+1:0] v;
      logic [LW-1:0]        r;
      v = $signed((LW+2)'(n)) + (LW+2)'(d);
      if (v < 1) r = LW'(1);
      else if (v > STEPS_PER_TRACK) r = LW'(STEPS_PER_TRACK);
      else r = LW'(v);
      return r;
   endfunction

   function automatic logic [AW-1:0] addr_of(logic [TW-1:0] t, logic [SW-1:0] s);
      return AW'(int'(t) * STEPS_PER_TRACK + int'(s));
   endfunction

   logic [4:0]        state_ff, state_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   wss_pkg::work_type item_ff, item_in;
   logic              run_ff, run_in;
   logic [TW-1:0]     edit_ff, edit_in;
   logic [1:0]        pend_mode_ff, pend_mode_in;
   logic [TW-1:0]     pend_trk_ff, pend_trk_in;
   logic [SW-1:0]     step_ff [TRACK_COUNT];
   logic [SW-1:0]     step_in [TRACK_COUNT];
   logic [LW-1:0]     len_ff [TRACK_COUNT];
   logic [LW-1:0]     len_in [TRACK_COUNT];
   logic [LW-1:0]     clip_len_ff, clip_len_in;
   logic [TW-1:0]     tgt_ff, tgt_in;
   logic [4:0]        ret_ff, ret_in;
   logic signed [15:0] cvo_ff [4];
   logic signed [15:0] cvo_in [4];
   logic [3:0]        gates_ff, gates_in;
   logic              sgate_ff, sgate_in;
   wss_pkg::rsp_type  rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic              st_we, cl_we;
   logic [AW-1:0]     st_waddr, st_raddr;
   logic [SW-1:0]     cl_waddr, cl_raddr;
   logic [DW-1:0]     st_wdata, st_rdata, cl_wdata, cl_rdata;

   logic [SW-1:0]     e_step, knob_step, mv_step;
   logic [LW-1:0]     e_len, knob_len;
   logic [AW-1:0]     e_addr;
   logic              ce, clk_a, clk_b, fire, hi;
   logic [TW-1:0]     oi;
   logic [SW-1:0]     clamp_step [TRACK_COUNT];
   logic [SW-1:0]     adv_step [TRACK_COUNT];

   wss_ram #(.WIDTH(DW), .DEPTH(STORE_DEPTH)) u_store (
      .clock(clock), .wr_en(st_we), .wr_addr(st_waddr), .wr_data(st_wdata),
      .rd_addr(st_raddr), .rd_data(st_rdata)
   );

   wss_ram #(.WIDTH(DW), .DEPTH(STEPS_PER_TRACK)) u_clip (
      .clock(clock), .wr_en(cl_we), .wr_addr(cl_waddr), .wr_data(cl_wdata),
      .rd_addr(cl_raddr), .rd_data(cl_rdata)
   );

   assign clk_a = item_ff.rise[wss_pkg::TRIG_CLK_A];
   assign clk_b = (!item_ff.b_conn && clk_a) || item_ff.rise[wss_pkg::TRIG_CLK_B];

   // clamp to length, then advance on the clock edges
   always_comb begin
      for (int i = 0; i < TRACK_COUNT; i++) begin
         clamp_step[i] = (LW'(step_ff[i]) >= len_ff[i]) ? SW'(len_ff[i] - 1'b1) : step_ff[i];
         adv_step[i] = clamp_step[i];
         if (run_ff && i < PLAYED && ((i < 2) ? clk_a : clk_b))
            adv_step[i] = move_to(clamp_step[i], 3'sd1, len_ff[i]);
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      item_in      = item_ff;
      run_in       = run_ff;
      edit_in      = edit_ff;
      pend_mode_in = pend_mode_ff;
      pend_trk_in  = pend_trk_ff;
      step_in      = step_ff;
      len_in       = len_ff;
      clip_len_in  = clip_len_ff;
      tgt_in       = tgt_ff;
      ret_in       = ret_ff;
      cvo_in       = cvo_ff;
      gates_in     = gates_ff;
      sgate_in     = sgate_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      st_we    = 1'b0;
      st_waddr = '0;
      st_wdata = '0;
      st_raddr = '0;
      cl_we    = 1'b0;
      cl_waddr = '0;
      cl_wdata = '0;
      cl_raddr = '0;
      q_pop    = 1'b0;
      e_step    = step_ff[edit_ff];
      e_len     = len_ff[edit_ff];
      e_addr    = addr_of(edit_ff, e_step);
      ce        = !run_ff || (edit_ff == STAGE);
      knob_len  = e_len;
      knob_step = e_step;
      mv_step   = e_step;
      fire      = 1'b0;
      hi        = 1'b0;
      oi        = cnt_ff[TW-1:0];

      case (state_ff)
         ST_CLEAR: begin
            st_we    = 1'b1;
            st_waddr = cnt_ff[AW-1:0];
            st_wdata = {16'd0, 1'b1};
            if (cnt_ff < CW'(STEPS_PER_TRACK)) begin
               cl_we    = 1'b1;
               cl_waddr = cnt_ff[SW-1:0];
               cl_wdata = {16'd0, 1'b1};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(STORE_DEPTH - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               item_in  = q_data;
               state_in = ST_FRONT;
            end
         end
         ST_FRONT: begin
            if (item_ff.rise[wss_pkg::TRIG_RUN]) run_in = !run_ff;
            cnt_in = '0;
            state_in = item_ff.rise[wss_pkg::TRIG_COPY] ? ST_COPY : ST_PDEC;
         end
         ST_COPY: begin
            st_raddr = addr_of(edit_ff, cnt_ff[SW-1:0]);
            if (cnt_ff != '0) begin
               cl_we    = 1'b1;
               cl_waddr = SW'(cnt_ff - 1'b1);
               cl_wdata = st_rdata;
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(STEPS_PER_TRACK)) begin
               clip_len_in = e_len;
               state_in    = ST_PDEC;
            end
         end
         ST_PDEC: begin
            state_in = ST_EDIT;
            if (item_ff.rise[wss_pkg::TRIG_PASTE]) begin
               if (cfg.paste_sync_mode == wss_pkg::SYNC_NOW || edit_ff == STAGE) begin
                  pend_mode_in = wss_pkg::PEND_NONE;
                  tgt_in   = edit_ff;
                  ret_in   = ST_EDIT;
                  cnt_in   = '0;
                  state_in = ST_PASTE;
               end else begin
                  pend_mode_in = cfg.paste_sync_mode[1] ? wss_pkg::PEND_START
                                                        : wss_pkg::PEND_CLOCK;
                  pend_trk_in  = edit_ff;
               end
            end
         end
         ST_PASTE: begin
            cl_raddr = cnt_ff[SW-1:0];
            if (cnt_ff != '0) begin
               st_we    = 1'b1;
               st_waddr = addr_of(tgt_ff, SW'(cnt_ff - 1'b1));
               st_wdata = cl_rdata;
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(STEPS_PER_TRACK)) begin
               len_in[tgt_ff] = clip_len_ff;
               if (LW'(step_ff[tgt_ff]) >= clip_len_ff)
                  step_in[tgt_ff] = SW'(clip_len_ff - 1'b1);
               state_in = ret_ff;
            end
         end
         ST_EDIT: begin
            if (item_ff.rise[wss_pkg::TRIG_CHANNEL])
               edit_in = (edit_ff == STAGE) ? '0 : edit_ff + 1'b1;
            state_in = item_ff.rise[wss_pkg::TRIG_GATE] ? ST_GREAD : ST_KNOB;
         end
         ST_GREAD: begin
            st_raddr = e_addr;
            state_in = ST_GWR;
         end
         ST_GWR: begin
            st_we    = 1'b1;
            st_waddr = e_addr;
            st_wdata = {st_rdata[DW-1:1], ~st_rdata[0]};
            state_in = ST_KNOB;
         end
         ST_KNOB: begin
            if (item_ff.len_delta != 3'sd0) knob_len = sat_len(e_len, item_ff.len_delta);
            len_in[edit_ff] = knob_len;
            if (item_ff.step_delta != 3'sd0 && ce)
               knob_step = move_to(e_step, item_ff.step_delta, knob_len);
            step_in[edit_ff] = knob_step;
            state_in = ST_CLK;
         end
         ST_CLK: begin
            step_in  = adv_step;
            state_in = ST_MOVE;
            fire = (int'(edit_ff) < PLAYED) && ((int'(edit_ff) < 2) ? clk_a : clk_b);
            if (run_ff && fire && (pend_mode_ff == wss_pkg::PEND_CLOCK ||
                (pend_mode_ff == wss_pkg::PEND_START && adv_step[edit_ff] == '0))) begin
               pend_mode_in = wss_pkg::PEND_NONE;
               tgt_in   = pend_trk_ff;
               ret_in   = ST_MOVE;
               cnt_in   = '0;
               state_in = ST_PASTE;
            end
         end
         ST_MOVE: begin
            if (item_ff.rise[wss_pkg::TRIG_LEFT] && ce) mv_step = move_to(mv_step, -3'sd1, e_len);
            if (item_ff.rise[wss_pkg::TRIG_RIGHT] && ce) mv_step = move_to(mv_step, 3'sd1, e_len);
            step_in[edit_ff] = mv_step;
            cnt_in   = '0;
            cvo_in   = '{default: '0};
            gates_in = '0;
            state_in = (item_ff.rise[wss_pkg::TRIG_WRITE] && ce) ? ST_WREAD : ST_ORD;
         end
         ST_WREAD: begin
            st_raddr = e_addr;
            state_in = ST_WWR;
         end
         ST_WWR: begin
            st_we    = 1'b1;
            st_waddr = e_addr;
            st_wdata = {wss_pkg::quantize(item_ff.cv_in, cfg.quantize_enable),
                        item_ff.gate_conn ? item_ff.gate_high : st_rdata[0]};
            if (cfg.autostep_enable) step_in[edit_ff] = move_to(e_step, 3'sd1, e_len);
            state_in = ST_ORD;
         end
         ST_ORD: begin
            st_raddr = addr_of(oi, step_ff[oi]);
            state_in = ST_OCAP;
         end
         ST_OCAP: begin
            hi = (int'(oi) < 2) ? item_ff.levels[wss_pkg::TRIG_CLK_A]
                                : item_ff.levels[wss_pkg::TRIG_CLK_B];
            if (run_ff) begin
               cvo_in[cnt_ff[1:0]] = st_rdata[DW-1:1];
               if (hi && st_rdata[0]) gates_in[cnt_ff[1:0]] = 1'b1;
            end else begin
               cvo_in[cnt_ff[1:0]] = cfg.monitor_mode ? st_rdata[DW-1:1]
                  : wss_pkg::quantize(item_ff.cv_in, cfg.quantize_enable);
               if (oi == edit_ff) gates_in[cnt_ff[1:0]] = 1'b1;
            end
            cnt_in   = cnt_ff + 1'b1;
            state_in = ST_ORD;
            if (cnt_ff == CW'(PLAYED - 1)) begin
               if (item_ff.rise[wss_pkg::TRIG_RESET]) begin
                  step_in      = '{default: '0};
                  pend_mode_in = wss_pkg::PEND_NONE;
               end
               state_in = ST_SREAD;
            end
         end
         ST_SREAD: begin
            st_raddr = e_addr;
            state_in = ST_SCAP;
         end
         ST_SCAP: begin
            sgate_in = st_rdata[0];
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.cv_out_0       = cvo_ff[0];
               rsp_in.cv_out_1       = cvo_ff[1];
               rsp_in.cv_out_2       = cvo_ff[2];
               rsp_in.cv_out_3       = cvo_ff[3];
               rsp_in.gate_outs      = gates_ff;
               rsp_in.selected_track = 3'(edit_ff);
               rsp_in.current_step   = 6'(e_step);
               rsp_in.track_length   = 7'(e_len);
               rsp_in.status_lights  = {pend_mode_ff != wss_pkg::PEND_NONE, ce, sgate_ff, run_ff};
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      tgt_ff      <= tgt_in;
      ret_ff      <= ret_in;
      cvo_ff      <= cvo_in;
      gates_ff    <= gates_in;
      sgate_ff    <= sgate_in;
      rsp_ff      <= rsp_in;
      pend_trk_ff <= pend_trk_in;
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         run_ff       <= 1'b1;
         edit_ff      <= '0;
         pend_mode_ff <= wss_pkg::PEND_NONE;
         step_ff      <= '{default: '0};
         len_ff       <= '{default: LW'(STEPS_PER_TRACK)};
         clip_len_ff  <= LW'(STEPS_PER_TRACK);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         run_ff       <= run_in;
         edit_ff      <= edit_in;
         pend_mode_ff <= pend_mode_in;
         step_ff      <= step_in;
         len_ff       <= len_in;
         clip_len_ff  <= clip_len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_edit_range: assert property (@(posedge clock) disable iff (reset)
      int'(edit_ff) < TRACK_COUNT)
      else $error("edited track out of range");

   a_step_in_len: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE |-> LW'(step_ff[edit_ff]) < len_ff[edit_ff])
      else $error("step index beyond track length at result");

   a_clear_once: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_CLEAR |=> state_ff != ST_CLEAR)
      else $error("clearing pass restarted");

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> state_ff == ST_FRONT)
      else $error("popped request not processed");

endmodule
